@@ sv/dual_mode_hms_stopwatch_assert.svh @@
// ----------------------------------------------------------------------------
// Stopwatch assertion macros
// Shared concurrent assertion forms, clocked on clk and idle during rst.
// ----------------------------------------------------------------------------
`ifndef DUAL_MODE_HMS_STOPWATCH_ASSERT_SVH
`define DUAL_MODE_HMS_STOPWATCH_ASSERT_SVH

// same-cycle implication
`define DMHS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DMHS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/dmhs_pkg.sv @@
// ----------------------------------------------------------------------------
// Stopwatch package
// Item layouts, field widths and time limits for the hh:mm:ss stopwatch.
// ----------------------------------------------------------------------------
`default_nettype none

package dmhs_pkg;

  localparam int unsigned HourW = 5;
  localparam int unsigned MsW   = 6;
  localparam int unsigned InW   = 16;
  localparam int unsigned OutW  = 24;

  localparam logic [HourW-1:0] HourMax = 5'd23;
  localparam logic [MsW-1:0]   MsMax   = 6'd59;

  typedef struct packed {
    logic [4:0] pad;
    logic       dec_seconds_level;
    logic       inc_seconds_level;
    logic       dec_minutes_level;
    logic       inc_minutes_level;
    logic       dec_hours_level;
    logic       inc_hours_level;
    logic       mode_level;
    logic       resume_press;
    logic       pause_press;
    logic       reset_press;
    logic       second_tick;
  } in_item_t;

  typedef struct packed {
    logic [3:0]       pad;
    logic             buzzer_on;
    logic             is_running;
    logic             counting_down;
    logic [MsW-1:0]   seconds_now;
    logic [MsW-1:0]   minutes_now;
    logic [HourW-1:0] hours_now;
  } out_item_t;

  typedef struct packed {
    logic mode;
    logic dec_s;
    logic inc_s;
    logic dec_m;
    logic inc_m;
    logic dec_h;
    logic inc_h;
  } levels_t;

endpackage

`default_nettype wire

@@ sv/dual_mode_hms_stopwatch.sv @@
// ----------------------------------------------------------------------------
// Dual mode hh:mm:ss stopwatch
// Up/down time counter with run control, buzzer and edge-detected adjust and mode buttons.
// ----------------------------------------------------------------------------
// One input item is one sample of the tick and button lines; each produces
// one result item with the time and flags after that sample. An item is
// taken when offered and s_tready is high: the state and result register update
// in the cycle of acceptance, and input is accepted whenever the result
// register is empty or its item is being taken, so one item per clock is
// sustained while m_tready stays high; the result shows in the cycle after.
`default_nettype none

module dual_mode_hms_stopwatch (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  // second_tick, reset_press, pause_press, resume_press, mode_level,
  // inc_hours_level, dec_hours_level, inc_minutes_level, dec_minutes_level,
  // inc_seconds_level, dec_seconds_level, 5 zero bits
  input  wire logic [dmhs_pkg::InW-1:0]   s_tdata,
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  // hours_now[4:0], minutes_now[5:0], seconds_now[5:0], counting_down,
  // is_running, buzzer_on, 4 zero bits
  output logic [dmhs_pkg::OutW-1:0]       m_tdata
);
  import dmhs_pkg::*;

  logic [HourW-1:0] hour_count, hour_count_next;
  logic [MsW-1:0]   minute_count, minute_count_next;
  logic [MsW-1:0]   second_count, second_count_next;
  logic             down_mode, down_mode_next;
  logic             run_flag, run_flag_next;
  logic             buzzer_flag, buzzer_flag_next;
  levels_t          previous_levels, levels, rise;
  in_item_t         in_item;
  out_item_t        out_item;
  logic             in_accept;

  assign in_item   = in_item_t'(s_tdata);
  assign s_tready  = !m_tvalid || m_tready;
  assign in_accept = s_tvalid && s_tready;

  assign levels = '{mode:  in_item.mode_level,
                    dec_s: in_item.dec_seconds_level,
                    inc_s: in_item.inc_seconds_level,
                    dec_m: in_item.dec_minutes_level,
                    inc_m: in_item.inc_minutes_level,
                    dec_h: in_item.dec_hours_level,
                    inc_h: in_item.inc_hours_level};
  assign rise = levels & ~previous_levels;

  always_comb begin
    hour_count_next   = hour_count;
    minute_count_next = minute_count;
    second_count_next = second_count;
    down_mode_next    = down_mode;
    buzzer_flag_next  = buzzer_flag;

    if (in_item.pause_press) begin
      run_flag_next = 1'b0;
    end else if (in_item.resume_press) begin
      run_flag_next = 1'b1;
    end else begin
      run_flag_next = run_flag;
    end

    if (in_item.second_tick && run_flag_next) begin
      if (down_mode) begin
        if (hour_count == '0 && minute_count == '0 && second_count == '0) begin
          buzzer_flag_next = 1'b1;
        end else if (second_count != '0) begin
          second_count_next = second_count - 6'd1;
        end else if (minute_count != '0) begin
          minute_count_next = minute_count - 6'd1;
          second_count_next = MsMax;
        end else begin
          hour_count_next   = hour_count - 5'd1;
          minute_count_next = MsMax;
          second_count_next = MsMax;
        end
      end else if (second_count < MsMax) begin
        second_count_next = second_count + 6'd1;
      end else begin
        second_count_next = '0;
        if (minute_count < MsMax) begin
          minute_count_next = minute_count + 6'd1;
        end else begin
          minute_count_next = '0;
          hour_count_next   = (hour_count < HourMax) ? hour_count + 5'd1 : '0;
        end
      end
    end

    if (rise.inc_h && hour_count_next < HourMax) hour_count_next = hour_count_next + 5'd1;
    if (rise.dec_h && hour_count_next != '0)     hour_count_next = hour_count_next - 5'd1;
    if (rise.inc_m && minute_count_next < MsMax) minute_count_next = minute_count_next + 6'd1;
    if (rise.dec_m && minute_count_next != '0)   minute_count_next = minute_count_next - 6'd1;
    if (rise.inc_s && second_count_next < MsMax) second_count_next = second_count_next + 6'd1;
    if (rise.dec_s && second_count_next != '0)   second_count_next = second_count_next - 6'd1;
    if (rise.mode) down_mode_next = !down_mode;

    if (in_item.reset_press) begin
      hour_count_next   = '0;
      minute_count_next = '0;
      second_count_next = '0;
      buzzer_flag_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hour_count      <= '0;
      minute_count    <= '0;
      second_count    <= '0;
      down_mode       <= 1'b0;
      run_flag        <= 1'b1;
      buzzer_flag     <= 1'b0;
      previous_levels <= '0;
      m_tvalid        <= 1'b0;
    end else begin
      if (in_accept) begin
        hour_count      <= hour_count_next;
        minute_count    <= minute_count_next;
        second_count    <= second_count_next;
        down_mode       <= down_mode_next;
        run_flag        <= run_flag_next;
        buzzer_flag     <= buzzer_flag_next;
        previous_levels <= levels;
        m_tvalid        <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_item <= '{pad:           '0,
                    buzzer_on:     buzzer_flag_next,
                    is_running:    run_flag_next,
                    counting_down: down_mode_next,
                    seconds_now:   second_count_next,
                    minutes_now:   minute_count_next,
                    hours_now:     hour_count_next};
    end
  end

  assign m_tdata = OutW'(out_item);

  `include "dual_mode_hms_stopwatch_assert.svh"

  `DMHS_ASSERT_NOW(a_time_range, m_tvalid, out_item.hours_now <= HourMax && out_item.minutes_now <= MsMax && out_item.seconds_now <= MsMax, "time out of range")
  `DMHS_ASSERT_NEXT(a_accept_result, in_accept, m_tvalid, "accepted item gave no result")
  `DMHS_ASSERT_NOW(a_no_stall_empty, !s_tready, m_tvalid, "input stalled with empty result register")
  `DMHS_ASSERT_NOW(a_buzzer_rise, $rose(buzzer_flag), $past(down_mode) && $past(in_accept), "buzzer set outside countdown")

endmodule

`default_nettype wire
